// File: rtl/core/sac_pkg.sv
// Package for the set-associative LRU cache tag model: types, constants and codes.
`default_nettype none

package sac_pkg;

	localparam int MAX_SET_BITS = 5;
	localparam int MAX_WAYS = 8;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int ADDR_W = 64;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd2;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_STORE = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;
	localparam logic [1:0] REQ_FETCH = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic is_hit;
		logic is_miss;
		logic is_eviction;
		logic is_last;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} res_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0] valid;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
		logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
	} row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_SECOND
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic update;
		logic second;
	} ctl_cmd_t;

	typedef struct packed {
		logic req_is_fetch;
		logic is_modify;
		logic res_free;
	} ctl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sac_ctrl.sv
// Controller state machine that sequences lookup, update and result loading.
`default_nettype none

module sac_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire sac_pkg::ctl_sts_t sts,
	output sac_pkg::ctl_cmd_t cmd
);

	sac_pkg::state_t state_q;
	sac_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sac_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			sac_pkg::ST_IDLE: begin
				if (req_valid && !sts.req_is_fetch) begin
					state_n = sac_pkg::ST_LOOKUP;
				end
			end
			sac_pkg::ST_LOOKUP: begin
				state_n = sac_pkg::ST_UPDATE;
			end
			sac_pkg::ST_UPDATE: begin
				if (sts.res_free) begin
					state_n = sts.is_modify ? sac_pkg::ST_SECOND : sac_pkg::ST_IDLE;
				end
			end
			sac_pkg::ST_SECOND: begin
				if (sts.res_free) begin
					state_n = sac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sac_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			sac_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			sac_pkg::ST_LOOKUP: begin
				cmd.rd_en = 1'b1;
			end
			sac_pkg::ST_UPDATE: begin
				cmd.update = sts.res_free;
			end
			sac_pkg::ST_SECOND: begin
				cmd.second = sts.res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/sac_dpath.sv
// Datapath: configuration, set memory, way compare, LRU update, counters and result register.
`default_nettype none

module sac_dpath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire sac_pkg::req_t req,
	output sac_pkg::res_t res,
	output logic res_valid,
	input wire logic res_ready,
	input wire sac_pkg::ctl_cmd_t cmd,
	output sac_pkg::ctl_sts_t sts
);

	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	logic [2:0] sb;
	logic [sac_pkg::WCNT_W-1:0] nw;
	logic [6:0] shamt;
	logic [sac_pkg::ADDR_W-1:0] addr_sh;
	logic [sac_pkg::SET_W-1:0] set_mask;
	logic [sac_pkg::SET_W-1:0] set_n;
	logic [sac_pkg::ADDR_W-1:0] tag_n;

	logic [sac_pkg::SET_W-1:0] set_q;
	logic [sac_pkg::ADDR_W-1:0] tag_q;
	logic mod_q;

	sac_pkg::row_t row_mem_q [sac_pkg::NUM_SETS];
	sac_pkg::row_t rd_row_q;
	logic [sac_pkg::NUM_SETS-1:0] row_vld_q;

	sac_pkg::row_t cur;
	sac_pkg::row_t nrow;
	logic hit_found;
	logic [sac_pkg::WAY_W-1:0] hit_way;
	logic emp_found;
	logic [sac_pkg::WAY_W-1:0] emp_way;
	logic [sac_pkg::WAY_W-1:0] vic_way;
	logic [sac_pkg::RANK_W-1:0] best;
	logic [sac_pkg::WAY_W-1:0] way_sel;
	logic evict;
	logic [sac_pkg::WCNT_W-1:0] old_rank;
	logic [sac_pkg::WCNT_W-1:0] rank_ext;

	logic [sac_pkg::CNT_W-1:0] hit_cnt_q;
	logic [sac_pkg::CNT_W-1:0] miss_cnt_q;
	logic [sac_pkg::CNT_W-1:0] ev_cnt_q;
	logic [sac_pkg::CNT_W-1:0] hit_cnt_n;
	logic [sac_pkg::CNT_W-1:0] miss_cnt_n;
	logic [sac_pkg::CNT_W-1:0] ev_cnt_n;

	sac_pkg::res_t res_q;
	logic res_valid_q;
	logic load;

	function automatic logic [sac_pkg::CNT_W-1:0] sat_inc(input logic [sac_pkg::CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= '0;
			block_bits_q <= '0;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				sac_pkg::CFG_SET_BITS: set_bits_q <= cfg_wdata[2:0];
				sac_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				sac_pkg::CFG_WAYS: ways_q <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (int'(set_bits_q) > sac_pkg::MAX_SET_BITS) begin
			sb = 3'(sac_pkg::MAX_SET_BITS);
		end else begin
			sb = set_bits_q;
		end
		if (ways_q == '0) begin
			nw = sac_pkg::WCNT_W'(1);
		end else if (int'(ways_q) > sac_pkg::MAX_WAYS) begin
			nw = sac_pkg::WCNT_W'(sac_pkg::MAX_WAYS);
		end else begin
			nw = sac_pkg::WCNT_W'(ways_q);
		end
		shamt = {1'b0, block_bits_q} + {4'd0, sb};
		addr_sh = req.address >> block_bits_q;
		for (int i = 0; i < sac_pkg::SET_W; i++) begin
			set_mask[i] = (i < int'(sb));
		end
		set_n = addr_sh[sac_pkg::SET_W-1:0] & set_mask;
		tag_n = shamt[6] ? '0 : (req.address >> shamt[5:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_n;
			tag_q <= tag_n;
			mod_q <= (req.req_type == sac_pkg::REQ_MODIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_row_q <= row_mem_q[set_q];
		end
		if (cmd.update) begin
			row_mem_q[set_q] <= nrow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.update) begin
			row_vld_q[set_q] <= 1'b1;
		end
	end

	always_comb begin
		cur = row_vld_q[set_q] ? rd_row_q : '0;
		hit_found = 1'b0;
		hit_way = '0;
		emp_found = 1'b0;
		emp_way = '0;
		for (int i = 0; i < sac_pkg::MAX_WAYS; i++) begin
			if (sac_pkg::WCNT_W'(i) < nw) begin
				if (cur.valid[i] && cur.tag[i] == tag_q && !hit_found) begin
					hit_found = 1'b1;
					hit_way = sac_pkg::WAY_W'(i);
				end
				if (!cur.valid[i] && !emp_found) begin
					emp_found = 1'b1;
					emp_way = sac_pkg::WAY_W'(i);
				end
			end
		end
		best = cur.rank[0];
		vic_way = '0;
		for (int i = 1; i < sac_pkg::MAX_WAYS; i++) begin
			if (sac_pkg::WCNT_W'(i) < nw && cur.rank[i] > best) begin
				best = cur.rank[i];
				vic_way = sac_pkg::WAY_W'(i);
			end
		end
		if (hit_found) begin
			way_sel = hit_way;
		end else if (emp_found) begin
			way_sel = emp_way;
		end else begin
			way_sel = vic_way;
		end
		evict = !hit_found && !emp_found;
		old_rank = hit_found ? sac_pkg::WCNT_W'(cur.rank[hit_way]) : nw;
		nrow = cur;
		if (!hit_found) begin
			nrow.valid[way_sel] = 1'b1;
			nrow.tag[way_sel] = tag_q;
		end
		for (int i = 0; i < sac_pkg::MAX_WAYS; i++) begin
			rank_ext = sac_pkg::WCNT_W'(cur.rank[i]);
			if (sac_pkg::WCNT_W'(i) < nw && sac_pkg::WAY_W'(i) != way_sel &&
					rank_ext < old_rank && rank_ext < nw - 1'b1) begin
				nrow.rank[i] = cur.rank[i] + 1'b1;
			end
		end
		nrow.rank[way_sel] = '0;
	end

	always_comb begin
		hit_cnt_n = hit_cnt_q;
		miss_cnt_n = miss_cnt_q;
		ev_cnt_n = ev_cnt_q;
		if (cmd.second) begin
			hit_cnt_n = sat_inc(hit_cnt_q);
		end else if (cmd.update) begin
			if (hit_found) begin
				hit_cnt_n = sat_inc(hit_cnt_q);
			end else begin
				miss_cnt_n = sat_inc(miss_cnt_q);
			end
			if (evict) begin
				ev_cnt_n = sat_inc(ev_cnt_q);
			end
		end
	end

	assign load = cmd.update || cmd.second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			ev_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			hit_cnt_q <= hit_cnt_n;
			miss_cnt_q <= miss_cnt_n;
			ev_cnt_q <= ev_cnt_n;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.is_hit <= cmd.second || hit_found;
			res_q.is_miss <= !cmd.second && !hit_found;
			res_q.is_eviction <= !cmd.second && evict;
			res_q.is_last <= cmd.second || !mod_q;
			res_q.hit_total <= hit_cnt_n;
			res_q.miss_total <= miss_cnt_n;
			res_q.eviction_total <= ev_cnt_n;
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	assign sts.req_is_fetch = (req.req_type == sac_pkg::REQ_FETCH);
	assign sts.is_modify = mod_q;
	assign sts.res_free = !res_valid_q || res_ready;

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_lru_cache_model.sv
// Top level of the set-associative LRU cache tag model.
//
// Requests arrive on the req channel (valid/ready) as a request type and a
// 64-bit address; results leave on the res channel (valid/ready). Loads and
// stores give one result, a modify gives two (its own outcome, then a hit),
// and an instruction fetch is taken and gives none.
// The configuration port writes set bits, block bits and way count with a
// single-cycle write enable; the user must write it only while the block is
// idle, and the block itself does not enforce this. The lookup state reads
// the set row from the set memory into a register; the update state compares
// all configured ways in parallel, writes the row back with the new tags and
// LRU ranks and loads the result register. A new request is taken once the
// previous one has loaded its last result. When the receiver stalls, the
// result register holds and the block may take the next request, which then
// waits before its update until the register is free. Reset sets zero set
// bits, zero block bits and one way, and clears the per-set valid flags,
// which make every line read as empty, and the totals; no clearing pass is
// needed.
`default_nettype none

module set_assoc_lru_cache_model (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic req_valid,
	output logic req_ready,
	input wire sac_pkg::req_t req,
	output logic res_valid,
	input wire logic res_ready,
	output sac_pkg::res_t res
);

	sac_pkg::ctl_cmd_t cmd;
	sac_pkg::ctl_sts_t sts;

	sac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts(sts),
		.cmd(cmd)
	);

	sac_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.res(res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

`default_nettype wire

// File: rtl/core/sac_checker.sv
// Port-level checker for the cache tag model and its bind to the top level.
`default_nettype none

module sac_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire sac_pkg::res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Result changed while stalled.");

	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.is_hit ^ res.is_miss))
		else $error("Result is not exactly one of hit and miss.");

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_eviction |-> res.is_miss)
		else $error("Eviction reported without a miss.");

	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid ||
			(res.hit_total >= $past(res.hit_total) &&
			res.miss_total >= $past(res.miss_total) &&
			res.eviction_total >= $past(res.eviction_total)))
		else $error("A total decreased between transactions.");

endmodule

bind set_assoc_lru_cache_model sac_checker u_sac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res)
);

`default_nettype wire
